// File: hdl/smg_pkg.sv
`timescale 1ns / 1ps

package smg_pkg;

	// Default sizing of the generator.
	localparam int DEF_MAX_LATITUDES  = 64;
	localparam int DEF_MAX_MERIDIANS  = 64;
	localparam int DEF_SINE_ROM_DEPTH = 1024;

	// Fixed field widths.
	localparam int KIND_W    = 2;
	localparam int DATA_W    = 16;	// signed Q1.14 coordinate
	localparam int FRAC_W    = 14;
	localparam int MAG_W     = 15;	// sine magnitude, 0 .. 16384
	localparam int PROD_W    = 2 * MAG_W;
	localparam int IDX_W     = 14;	// vertex index
	localparam int PHASE_W   = 17;	// 65536 units per half turn
	localparam int OFF_W     = 15;	// offset within one quadrant
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int Q14_ONE = 16384;

	// Element kinds on the result port.
	localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TRI    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd2;

	// Vertex flavors carried down the pipeline.
	localparam logic [1:0] VX_NORTH = 2'd0;
	localparam logic [1:0] VX_SOUTH = 2'd1;
	localparam logic [1:0] VX_RING  = 2'd2;

	// Register map.
	localparam logic [CFG_IDX_W-1:0] REG_LATITUDES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MERIDIANS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_STEP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZ_STEP = 2'd3;

	localparam int LAT_RESET        = 8;
	localparam int MER_RESET        = 8;
	localparam int VERT_STEP_RESET  = 7282;
	localparam int HORIZ_STEP_RESET = 8192;

	// Sine table generation constants (Q30).
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [1:0]         vx;
		logic [PHASE_W-1:0] v_angle;
		logic [PHASE_W-1:0] h_angle;
		logic [IDX_W-1:0]   corner_a;
		logic [IDX_W-1:0]   corner_b;
		logic [IDX_W-1:0]   corner_c;
		logic               last;
	} item_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} sine_t;

	function automatic logic signed [DATA_W-1:0] to_q14(input sine_t s);
		logic signed [DATA_W-1:0] m;
		m = signed'(DATA_W'(s.mag));
		return s.neg ? -m : m;
	endfunction

endpackage

// File: hdl/smg_sine_rom.sv
`timescale 1ns / 1ps

module smg_sine_rom #(
	parameter int DEPTH = smg_pkg::DEF_SINE_ROM_DEPTH
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [smg_pkg::PHASE_W-1:0]  phase,
	output smg_pkg::sine_t               sin_s2,
	output smg_pkg::sine_t               cos_s2
);
	import smg_pkg::*;

	localparam int AW = $clog2(DEPTH + 1);
	localparam int PW = OFF_W + AW;

	// Quarter wave, DEPTH+1 entries, built at elaboration from a Q30 Taylor series.
	logic [MAG_W-1:0] rom_tbl [DEPTH+1];

	for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
		localparam logic [63:0] T   = (HALF_PI_Q30 * 64'(k)) / 64'(DEPTH);
		localparam logic [63:0] T2  = (T * T) >> 30;
		localparam logic [63:0] TM1 = ((T * T2) >> 30) / 64'd6;
		localparam logic [63:0] TM2 = ((TM1 * T2) >> 30) / 64'd20;
		localparam logic [63:0] TM3 = ((TM2 * T2) >> 30) / 64'd42;
		localparam logic [63:0] TM4 = ((TM3 * T2) >> 30) / 64'd72;
		localparam logic [63:0] TM5 = ((TM4 * T2) >> 30) / 64'd110;
		localparam logic [63:0] TM6 = ((TM5 * T2) >> 30) / 64'd156;
		localparam logic [63:0] S   = T - TM1 + TM2 - TM3 + TM4 - TM5 + TM6;
		localparam logic [63:0] SC  = (S > ONE_Q30) ? ONE_Q30 : S;
		localparam logic [63:0] VAL = (SC + 64'd32768) >> 16;
		localparam logic [MAG_W-1:0] ENTRY = (k == 0) ? MAG_W'(0) :
			(k == DEPTH) ? MAG_W'(Q14_ONE) : VAL[MAG_W-1:0];
		assign rom_tbl[k] = ENTRY;
	end

	// Scale the in-quadrant offset to a table index and mirror it in odd quadrants.
	function automatic logic [AW-1:0] rom_index(input logic [PHASE_W-1:0] ph);
		logic [PW-1:0] scaled;
		logic [AW-1:0] idx;
		scaled = PW'(ph[OFF_W-1:0]) * PW'(DEPTH) + (PW'(1) << (OFF_W - 1));
		idx = scaled[PW-1:OFF_W];
		if (idx > AW'(DEPTH)) begin
			idx = AW'(DEPTH);
		end
		return ph[OFF_W] ? AW'(DEPTH) - idx : idx;
	endfunction

	logic [PHASE_W-1:0] cos_phase;
	logic [AW-1:0]      sin_idx;
	logic [AW-1:0]      cos_idx;

	assign cos_phase = phase + PHASE_W'(1 << OFF_W);
	assign sin_idx   = rom_index(phase);
	assign cos_idx   = rom_index(cos_phase);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s2.mag <= rom_tbl[sin_idx];
			sin_s2.neg <= phase[PHASE_W-1];
			cos_s2.mag <= rom_tbl[cos_idx];
			cos_s2.neg <= cos_phase[PHASE_W-1];
		end
	end

endmodule

// File: hdl/smg_vtx_math.sv
`timescale 1ns / 1ps

module smg_vtx_math (
	input  logic                               clk,
	input  logic                               en_s3,
	input  logic                               en_s4,
	input  smg_pkg::item_t                     item_s2,
	input  smg_pkg::sine_t                     sin_v,
	input  smg_pkg::sine_t                     cos_v,
	input  smg_pkg::sine_t                     sin_h,
	input  smg_pkg::sine_t                     cos_h,
	output logic [smg_pkg::KIND_W-1:0]         kind,
	output logic signed [smg_pkg::DATA_W-1:0]  pos_x,
	output logic signed [smg_pkg::DATA_W-1:0]  pos_y,
	output logic signed [smg_pkg::DATA_W-1:0]  pos_z,
	output logic signed [smg_pkg::DATA_W-1:0]  tan_x,
	output logic signed [smg_pkg::DATA_W-1:0]  tan_z,
	output logic [smg_pkg::IDX_W-1:0]          corner_a,
	output logic [smg_pkg::IDX_W-1:0]          corner_b,
	output logic [smg_pkg::IDX_W-1:0]          corner_c,
	output logic                               last
);
	import smg_pkg::*;

	// Q28 magnitude to Q14, rounded half away from zero.
	function automatic logic signed [DATA_W-1:0] round_q14(input logic [PROD_W-1:0] m,
			input logic neg);
		logic [PROD_W:0]          sum;
		logic signed [DATA_W-1:0] r;
		sum = {1'b0, m} + (PROD_W + 1)'(1 << (FRAC_W - 1));
		r = signed'(sum[FRAC_W +: DATA_W]);
		return neg ? -r : r;
	endfunction

	item_t                    item_s3;
	logic [PROD_W-1:0]        prod_x_s3;
	logic [PROD_W-1:0]        prod_z_s3;
	logic                     neg_x_s3;
	logic                     neg_z_s3;
	logic signed [DATA_W-1:0] cv_s3;
	logic signed [DATA_W-1:0] ch_s3;
	logic signed [DATA_W-1:0] nsh_s3;
	sine_t                    nsin_h;

	assign nsin_h = '{neg: !sin_h.neg, mag: sin_h.mag};

	always_ff @(posedge clk) begin
		if (en_s3) begin
			item_s3   <= item_s2;
			prod_x_s3 <= PROD_W'(sin_v.mag) * PROD_W'(sin_h.mag);
			prod_z_s3 <= PROD_W'(sin_v.mag) * PROD_W'(cos_h.mag);
			neg_x_s3  <= sin_v.neg ^ sin_h.neg;
			neg_z_s3  <= sin_v.neg ^ cos_h.neg;
			cv_s3     <= to_q14(cos_v);
			ch_s3     <= to_q14(cos_h);
			nsh_s3    <= to_q14(nsin_h);
		end
	end

	logic signed [DATA_W-1:0] px_d, py_d, pz_d, tx_d, tz_d;

	always_comb begin
		px_d = '0;
		py_d = '0;
		pz_d = '0;
		tx_d = '0;
		tz_d = '0;
		if (item_s3.kind == KIND_VERTEX) begin
			case (item_s3.vx)
				VX_RING: begin
					px_d = round_q14(prod_x_s3, neg_x_s3);
					py_d = cv_s3;
					pz_d = round_q14(prod_z_s3, neg_z_s3);
					tx_d = ch_s3;
					tz_d = nsh_s3;
				end
				VX_SOUTH: begin
					py_d = -DATA_W'(Q14_ONE);
					tx_d = DATA_W'(Q14_ONE);
				end
				default: begin
					py_d = DATA_W'(Q14_ONE);
					tx_d = DATA_W'(Q14_ONE);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			kind     <= item_s3.kind;
			pos_x    <= px_d;
			pos_y    <= py_d;
			pos_z    <= pz_d;
			tan_x    <= tx_d;
			tan_z    <= tz_d;
			corner_a <= item_s3.corner_a;
			corner_b <= item_s3.corner_b;
			corner_c <= item_s3.corner_c;
			last     <= item_s3.last;
		end
	end

endmodule

// File: hdl/smg_ctrl.sv
`timescale 1ns / 1ps

module smg_ctrl #(
	parameter int MAX_LATITUDES = smg_pkg::DEF_MAX_LATITUDES,
	parameter int MAX_MERIDIANS = smg_pkg::DEF_MAX_MERIDIANS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [smg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smg_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic                            restart,
	input  logic                            adv_s2,
	output logic                            valid_s1,
	output smg_pkg::item_t                  item_s1
);
	import smg_pkg::*;

	localparam int LAT_W  = $clog2(MAX_LATITUDES + 1);
	localparam int MER_W  = $clog2(MAX_MERIDIANS + 1);
	localparam int RING_W = $clog2(MAX_LATITUDES + 2);
	localparam int PT_W   = $clog2(2 * MAX_MERIDIANS);
	localparam int PTS_W  = MER_W + 1;

	localparam int LAT_INIT = (LAT_RESET > MAX_LATITUDES) ? MAX_LATITUDES : LAT_RESET;
	localparam int MER_INIT = (MER_RESET > MAX_MERIDIANS) ? MAX_MERIDIANS : MER_RESET;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_VERT = 2'd1;
	localparam logic [1:0] MODE_TRI  = 2'd2;

	logic [LAT_W-1:0]   lat_q;
	logic [MER_W-1:0]   mer_q;
	logic [CFG_W-1:0]   vstep_q;
	logic [CFG_W-1:0]   hstep_q;

	logic [1:0]         mode_q, mode_d;
	logic [RING_W-1:0]  ring_q, ring_d;
	logic [PT_W-1:0]    point_q, point_d;
	logic               half_q, half_d;
	logic [PHASE_W-1:0] vang_q, vang_d;
	logic [PHASE_W-1:0] hang_q, hang_d;
	logic [IDX_W-1:0]   prev_base_q, prev_base_d;
	logic [IDX_W-1:0]   cur_base_q, cur_base_d;

	logic [PTS_W-1:0]   pts;
	logic [PTS_W-1:0]   pt_inc;
	logic               row_end;
	logic [IDX_W-1:0]   j_idx;
	logic [IDX_W-1:0]   jn_idx;
	logic [RING_W-1:0]  lat_ext;
	logic               advance;
	logic               accept;
	item_t              item_d;

	assign req_ready = !valid_s1 || adv_s2;
	assign accept    = req_valid && req_ready;

	assign pts     = {mer_q, 1'b0};
	assign pt_inc  = PTS_W'(point_q) + PTS_W'(1);
	assign row_end = pt_inc >= pts;
	assign j_idx   = IDX_W'(point_q);
	assign jn_idx  = row_end ? '0 : IDX_W'(pt_inc);
	assign lat_ext = RING_W'(lat_q);

	always_comb begin
		item_d      = '0;
		mode_d      = mode_q;
		ring_d      = ring_q;
		point_d     = point_q;
		half_d      = half_q;
		vang_d      = vang_q;
		hang_d      = hang_q;
		prev_base_d = prev_base_q;
		cur_base_d  = cur_base_q;
		advance     = 1'b0;

		if (restart) begin
			item_d.kind = KIND_VERTEX;
			item_d.vx   = VX_NORTH;
			mode_d      = MODE_VERT;
			ring_d      = RING_W'(1);
			point_d     = '0;
			half_d      = 1'b0;
			vang_d      = PHASE_W'(vstep_q);
			hang_d      = '0;
			prev_base_d = '0;
			cur_base_d  = '0;
		end else begin
			case (mode_q)
				MODE_VERT: begin
					item_d.kind = KIND_VERTEX;
					if (ring_q > lat_ext) begin
						item_d.vx   = VX_SOUTH;
						mode_d      = MODE_TRI;
						ring_d      = RING_W'(1);
						point_d     = '0;
						half_d      = 1'b0;
						prev_base_d = '0;
						cur_base_d  = IDX_W'(1);
					end else begin
						item_d.vx      = VX_RING;
						item_d.v_angle = vang_q;
						item_d.h_angle = hang_q;
						if (row_end) begin
							point_d = '0;
							hang_d  = '0;
							ring_d  = ring_q + RING_W'(1);
							vang_d  = vang_q + PHASE_W'(vstep_q);
						end else begin
							point_d = PT_W'(pt_inc);
							hang_d  = hang_q + PHASE_W'(hstep_q);
						end
					end
				end
				MODE_TRI: begin
					item_d.kind = KIND_TRI;
					advance     = 1'b1;
					if (ring_q <= RING_W'(1)) begin
						// Cap around the north pole.
						item_d.corner_a = prev_base_q;
						item_d.corner_b = cur_base_q + j_idx;
						item_d.corner_c = cur_base_q + jn_idx;
					end else if (ring_q <= lat_ext) begin
						// Two triangles per quad between neighboring rings.
						if (!half_q) begin
							item_d.corner_a = prev_base_q + j_idx;
							item_d.corner_b = cur_base_q + j_idx;
							item_d.corner_c = cur_base_q + jn_idx;
							half_d          = 1'b1;
							advance         = 1'b0;
						end else begin
							item_d.corner_a = prev_base_q + j_idx;
							item_d.corner_b = cur_base_q + jn_idx;
							item_d.corner_c = prev_base_q + jn_idx;
							half_d          = 1'b0;
						end
					end else begin
						// Cap around the south pole; the row end closes the mesh.
						item_d.corner_a = prev_base_q + j_idx;
						item_d.corner_b = cur_base_q;
						item_d.corner_c = prev_base_q + jn_idx;
						item_d.last     = row_end;
						if (row_end) begin
							mode_d  = MODE_IDLE;
							ring_d  = '0;
							point_d = '0;
							half_d  = 1'b0;
							advance = 1'b0;
						end
					end
					if (advance) begin
						if (row_end) begin
							point_d     = '0;
							ring_d      = ring_q + RING_W'(1);
							prev_base_d = cur_base_q;
							cur_base_d  = cur_base_q + IDX_W'(pts);
						end else begin
							point_d = PT_W'(pt_inc);
						end
					end
				end
				default: begin
					item_d.kind = KIND_IDLE;
				end
			endcase
		end
	end

	// Configuration registers; latitude and meridian counts are clamped on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q   <= LAT_W'(LAT_INIT);
			mer_q   <= MER_W'(MER_INIT);
			vstep_q <= CFG_W'(VERT_STEP_RESET);
			hstep_q <= CFG_W'(HORIZ_STEP_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LATITUDES: begin
					if (cfg_data == '0) begin
						lat_q <= LAT_W'(1);
					end else if (cfg_data > CFG_W'(MAX_LATITUDES)) begin
						lat_q <= LAT_W'(MAX_LATITUDES);
					end else begin
						lat_q <= LAT_W'(cfg_data);
					end
				end
				REG_MERIDIANS: begin
					if (cfg_data < CFG_W'(2)) begin
						mer_q <= MER_W'(2);
					end else if (cfg_data > CFG_W'(MAX_MERIDIANS)) begin
						mer_q <= MER_W'(MAX_MERIDIANS);
					end else begin
						mer_q <= MER_W'(cfg_data);
					end
				end
				REG_VERT_STEP: begin
					vstep_q <= cfg_data;
				end
				default: begin
					hstep_q <= cfg_data;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			ring_q      <= '0;
			point_q     <= '0;
			half_q      <= 1'b0;
			vang_q      <= '0;
			hang_q      <= '0;
			prev_base_q <= '0;
			cur_base_q  <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept) begin
				mode_q      <= mode_d;
				ring_q      <= ring_d;
				point_q     <= point_d;
				half_q      <= half_d;
				vang_q      <= vang_d;
				hang_q      <= hang_d;
				prev_base_q <= prev_base_d;
				cur_base_q  <= cur_base_d;
			end
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready) begin
			item_s1 <= item_d;
		end
	end

	a_restart_enters_vertices: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart |=> mode_q == MODE_VERT && ring_q == RING_W'(1) && point_q == '0)
		else $error("restart did not enter the vertex pass at ring one");

	a_last_ends_mesh: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !restart && mode_q == MODE_TRI && item_d.last |=> mode_q == MODE_IDLE)
		else $error("mesh did not go idle after its final triangle");

	a_idle_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !restart && mode_q == MODE_IDLE |=> valid_s1 && item_s1.kind == KIND_IDLE)
		else $error("advance while idle did not produce an idle word");

endmodule

// File: hdl/sphere_mesh_generator.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Payload
// cfg      in   cfg_we (no wait)       cfg_index, cfg_data
// req      in   req_valid / req_ready  restart
// rsp      out  rsp_valid / rsp_ready  kind, pos_x/y/z, tan_x/z, corner_a/b/c, last
//
// Every request word yields exactly one response word. It passes through the input
// register, the registered sine table read, the product register and the output register
// in that order before it appears on the response port. A new request word is taken every
// cycle unless rsp_ready back-pressure has filled the pipeline.
// Reset is asynchronous: mesh state goes idle and the registers return to their defaults.
// The sine table is constant logic, so no clearing pass follows reset.
// A stall on rsp_ready fills empty pipeline slots first; req_ready drops only when
// all four stages hold words.
module sphere_mesh_generator #(
	parameter int MAX_LATITUDES  = smg_pkg::DEF_MAX_LATITUDES,
	parameter int MAX_MERIDIANS  = smg_pkg::DEF_MAX_MERIDIANS,
	parameter int SINE_ROM_DEPTH = smg_pkg::DEF_SINE_ROM_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [smg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smg_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic                               restart,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic [smg_pkg::KIND_W-1:0]         kind,
	output logic signed [smg_pkg::DATA_W-1:0]  pos_x,
	output logic signed [smg_pkg::DATA_W-1:0]  pos_y,
	output logic signed [smg_pkg::DATA_W-1:0]  pos_z,
	output logic signed [smg_pkg::DATA_W-1:0]  tan_x,
	output logic signed [smg_pkg::DATA_W-1:0]  tan_z,
	output logic [smg_pkg::IDX_W-1:0]          corner_a,
	output logic [smg_pkg::IDX_W-1:0]          corner_b,
	output logic [smg_pkg::IDX_W-1:0]          corner_c,
	output logic                               last
);
	import smg_pkg::*;

	// Stage valids. Each stage loads when it is empty or when the stage after it moves,
	// so bubbles collapse under back-pressure.
	logic  valid_s1, valid_s2, valid_s3, valid_s4;
	logic  en_s2, en_s3, en_s4;
	item_t item_s1, item_s2;
	sine_t sin_v, cos_v, sin_h, cos_h;

	assign en_s4     = !valid_s4 || rsp_ready;
	assign en_s3     = !valid_s3 || en_s4;
	assign en_s2     = !valid_s2 || en_s3;
	assign rsp_valid = valid_s4;

	// Stage 1: mesh sequencer, registers and the element descriptor.
	smg_ctrl #(
		.MAX_LATITUDES (MAX_LATITUDES),
		.MAX_MERIDIANS (MAX_MERIDIANS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.restart   (restart),
		.adv_s2    (en_s2),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	// Stage 2: sine and cosine of the ring angle and of the point angle.
	smg_sine_rom #(
		.DEPTH (SINE_ROM_DEPTH)
	) u_rom_v (
		.clk    (clk),
		.en     (en_s2),
		.phase  (item_s1.v_angle),
		.sin_s2 (sin_v),
		.cos_s2 (cos_v)
	);

	smg_sine_rom #(
		.DEPTH (SINE_ROM_DEPTH)
	) u_rom_h (
		.clk    (clk),
		.en     (en_s2),
		.phase  (item_s1.h_angle),
		.sin_s2 (sin_h),
		.cos_s2 (cos_h)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2 <= item_s1;
		end
	end

	// Stages 3 and 4: magnitude products, then rounding and field selection.
	smg_vtx_math u_vtx (
		.clk      (clk),
		.en_s3    (en_s3),
		.en_s4    (en_s4),
		.item_s2  (item_s2),
		.sin_v    (sin_v),
		.cos_v    (cos_v),
		.sin_h    (sin_h),
		.cos_h    (cos_h),
		.kind     (kind),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.tan_x    (tan_x),
		.tan_z    (tan_z),
		.corner_a (corner_a),
		.corner_b (corner_b),
		.corner_c (corner_c),
		.last     (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// The request side only stalls when the whole pipeline is full and the output is held.
	a_ready_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready && valid_s1 && valid_s2 && valid_s3)
		else $error("request side stalled without output back-pressure");

	a_last_is_triangle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && last |-> kind == KIND_TRI && pos_x == '0 && pos_y == '0 && tan_x == '0)
		else $error("last flag on a word that is not a clean triangle");

	a_vertex_no_corners: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_VERTEX |->
			corner_a == '0 && corner_b == '0 && corner_c == '0 && !last)
		else $error("vertex word carries triangle fields");

endmodule
